FILE: rtl/hse_pkg.sv
package hse_pkg;

    // Store geometry.
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;
    localparam int DATA_W   = 32;

    // Operations that the controller asks of the datapath.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_FETCH,
        DP_START_BUILD,
        DP_START_SORT,
        DP_SIFT_RD,
        DP_SIFT_WR,
        DP_EMIT_RD,
        DP_EMIT_LD
    } dp_op_t;

    // Command bundle from controller to datapath.
    typedef struct packed {
        dp_op_t           op;
        logic [IDX_W-1:0] addr_a;
        logic [IDX_W-1:0] addr_b;
        logic [CNT_W-1:0] size;
        logic             last_out;
        logic             dropped;
    } dp_cmd_t;

    // Status bundle from datapath to controller.
    typedef struct packed {
        logic sift_done;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/hse_if.sv
// Input channel: one value to be sorted per word.
interface hse_in_if;
    import hse_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     last;

    modport source (output valid, output value, output last, input ready);
    modport sink (input valid, input value, input last, output ready);
endinterface

// Output channel: one sorted value per word.
interface hse_out_if;
    import hse_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     dropped;

    modport source (output valid, output sorted_value, output last_out, output dropped,
                    input ready);
    modport sink (input valid, input sorted_value, input last_out, input dropped,
                  output ready);
endinterface

FILE: rtl/hse_datapath.sv
module hse_datapath
    import hse_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    input  logic signed [DATA_W-1:0] in_value,
    output dp_status_t               status,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     last_out,
    output logic                     dropped
);

    logic signed [DATA_W-1:0] heap_mem [CAPACITY];

    logic signed [DATA_W-1:0] rd_a_reg;
    logic signed [DATA_W-1:0] rd_b_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] val_next;
    logic [IDX_W-1:0]         node_reg;
    logic [IDX_W-1:0]         node_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DATA_W-1:0] out_value_reg;
    logic                     out_last_reg;
    logic                     out_dropped_reg;

    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr_a;
    logic [IDX_W-1:0]         rd_addr_b;

    logic [IDX_W:0]           left_idx;
    logic [IDX_W+1:0]         right_idx;
    logic                     left_ok;
    logic                     right_ok;
    logic                     take_l;
    logic                     take_r;
    logic                     out_free;

    // Child positions of the node being sifted, and whether they lie in the heap.
    assign left_idx  = {node_reg, 1'b1};
    assign right_idx = {1'b0, left_idx} + (IDX_W+2)'(1);
    assign left_ok   = left_idx < cmd.size;
    assign right_ok  = right_idx < {1'b0, cmd.size};

    // A child moves up only when strictly larger than the value being sifted.
    assign take_l = left_ok && (rd_a_reg > val_reg);
    assign take_r = right_ok && (rd_b_reg > (take_l ? rd_a_reg : val_reg));

    assign out_free         = !out_valid_reg || out_ready;
    assign status.sift_done = !(take_l || take_r);
    assign status.out_free  = out_free;

    // Memory port selection and sift registers.
    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = cmd.addr_a;
        wr_data   = in_value;
        rd_en     = 1'b0;
        rd_addr_a = cmd.addr_a;
        rd_addr_b = cmd.addr_b;
        val_next  = val_reg;
        node_next = node_reg;
        unique case (cmd.op)
            DP_LOAD:
            begin
                wr_en = 1'b1;
            end
            DP_FETCH, DP_EMIT_RD:
            begin
                rd_en = 1'b1;
            end
            DP_START_BUILD:
            begin
                val_next  = rd_a_reg;
                node_next = cmd.addr_a;
            end
            DP_START_SORT:
            begin
                // Old root goes to the end of the heap; the end value sifts from the root.
                wr_en     = 1'b1;
                wr_addr   = cmd.addr_b;
                wr_data   = rd_a_reg;
                val_next  = rd_b_reg;
                node_next = '0;
            end
            DP_SIFT_RD:
            begin
                rd_en     = 1'b1;
                rd_addr_a = left_idx[IDX_W-1:0];
                rd_addr_b = right_idx[IDX_W-1:0];
            end
            DP_SIFT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = node_reg;
                if (take_r)
                begin
                    wr_data   = rd_b_reg;
                    node_next = right_idx[IDX_W-1:0];
                end
                else if (take_l)
                begin
                    wr_data   = rd_a_reg;
                    node_next = left_idx[IDX_W-1:0];
                end
                else
                begin
                    wr_data = val_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Heap store with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= heap_mem[rd_addr_a];
            rd_b_reg <= heap_mem[rd_addr_b];
        end
    end

    // Sift value and position.
    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        node_reg <= node_next;
    end

    // Output register holds a word until the receiver takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.op == DP_EMIT_LD)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_EMIT_LD)
        begin
            out_value_reg   <= rd_a_reg;
            out_last_reg    <= cmd.last_out;
            out_dropped_reg <= cmd.dropped;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = out_value_reg;
    assign last_out     = out_last_reg;
    assign dropped      = out_dropped_reg;

endmodule

FILE: rtl/hse_controller.sv
module hse_controller
    import hse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_last,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_BLD_FETCH = 9'b000000010,
        ST_BLD_START = 9'b000000100,
        ST_SIFT_RD   = 9'b000001000,
        ST_SIFT_WR   = 9'b000010000,
        ST_SRT_FETCH = 9'b000100000,
        ST_SRT_START = 9'b001000000,
        ST_EMIT_RD   = 9'b010000000,
        ST_EMIT_LD   = 9'b100000000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             overflow_reg;
    logic             overflow_next;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] n_next;
    logic [CNT_W-1:0] end_reg;
    logic [CNT_W-1:0] end_next;
    logic [IDX_W-1:0] build_reg;
    logic [IDX_W-1:0] build_next;
    logic [IDX_W-1:0] emit_reg;
    logic [IDX_W-1:0] emit_next;
    logic             phase_reg;
    logic             phase_next;

    // Sequencing of load, heap build, sort-down and emit.
    always_comb
    begin
        logic [CNT_W-1:0] n_val;
        logic             emit_last;

        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        n_next        = n_reg;
        end_next      = end_reg;
        build_next    = build_reg;
        emit_next     = emit_reg;
        phase_next    = phase_reg;
        in_ready      = 1'b0;
        n_val         = count_reg;
        emit_last     = ({1'b0, emit_reg} + CNT_W'(1)) == n_reg;

        cmd          = '0;
        cmd.op       = DP_NOP;
        cmd.size     = phase_reg ? end_reg : n_reg;
        cmd.dropped  = overflow_reg;
        cmd.last_out = emit_last;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (count_reg < CNT_W'(CAPACITY))
                    begin
                        cmd.op     = DP_LOAD;
                        cmd.addr_a = count_reg[IDX_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                        n_val      = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        n_next = n_val;
                        if (n_val >= CNT_W'(2))
                        begin
                            build_next = IDX_W'(n_val >> 1) - IDX_W'(1);
                            phase_next = 1'b0;
                            state_next = ST_BLD_FETCH;
                        end
                        else
                        begin
                            emit_next  = '0;
                            state_next = ST_EMIT_RD;
                        end
                    end
                end
            end
            ST_BLD_FETCH:
            begin
                cmd.op     = DP_FETCH;
                cmd.addr_a = build_reg;
                state_next = ST_BLD_START;
            end
            ST_BLD_START:
            begin
                cmd.op     = DP_START_BUILD;
                cmd.addr_a = build_reg;
                state_next = ST_SIFT_RD;
            end
            ST_SIFT_RD:
            begin
                cmd.op     = DP_SIFT_RD;
                state_next = ST_SIFT_WR;
            end
            ST_SIFT_WR:
            begin
                cmd.op = DP_SIFT_WR;
                if (!status.sift_done)
                begin
                    state_next = ST_SIFT_RD;
                end
                else if (!phase_reg)
                begin
                    if (build_reg == '0)
                    begin
                        phase_next = 1'b1;
                        end_next   = n_reg;
                        state_next = ST_SRT_FETCH;
                    end
                    else
                    begin
                        build_next = build_reg - IDX_W'(1);
                        state_next = ST_BLD_FETCH;
                    end
                end
                else if (end_reg > CNT_W'(1))
                begin
                    state_next = ST_SRT_FETCH;
                end
                else
                begin
                    emit_next  = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_SRT_FETCH:
            begin
                cmd.op     = DP_FETCH;
                cmd.addr_a = '0;
                cmd.addr_b = IDX_W'(end_reg - CNT_W'(1));
                state_next = ST_SRT_START;
            end
            ST_SRT_START:
            begin
                cmd.op     = DP_START_SORT;
                cmd.addr_b = IDX_W'(end_reg - CNT_W'(1));
                end_next   = end_reg - CNT_W'(1);
                state_next = ST_SIFT_RD;
            end
            ST_EMIT_RD:
            begin
                cmd.op     = DP_EMIT_RD;
                cmd.addr_a = emit_reg;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (status.out_free)
                begin
                    cmd.op = DP_EMIT_LD;
                    if (emit_last)
                    begin
                        count_next    = '0;
                        overflow_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        emit_next  = emit_reg + IDX_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            phase_reg    <= phase_next;
        end
    end

    // Loop indices, set before use in every pass.
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        end_reg   <= end_next;
        build_reg <= build_next;
        emit_reg  <= emit_next;
    end

endmodule

FILE: rtl/heap_sort_engine.sv
// Heap sort engine for one set of signed 32-bit values at a time.
// in_ch carries one value per word; the word with last set closes the set.
// Up to 64 values are stored; further words of the set are discarded and
// every result word of that set then has dropped set.
// Input words are taken at one per cycle while the set loads. After the last
// word, in_ch.ready stays low while the block builds a max-heap and sorts it
// down in place, then sends the set on out_ch in ascending order, last_out
// set on the final word.
// One sift unit does all the work. A sift pass has a setup of fetch and start,
// then for each heap level visited a store read, then compare and write back, and
// visits one level more than it moves the value down. For n values there are
// n/2 build passes and n-1 sort passes. Each result word is read from the store
// and then loaded into the output register.
// in_ch.ready returns once the final result word sits in the output register.
// If the receiver stalls, the output register holds its word and the engine
// waits; no word is lost.
// After reset the store count and drop flag are clear and the block is ready.
module heap_sort_engine
    import hse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    hse_in_if.sink    in_ch,
    hse_out_if.source out_ch
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer.
    hse_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_last  (in_ch.last),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Heap store, sift unit and output register.
    hse_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_value     (in_ch.value),
        .status       (status),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .sorted_value (out_ch.sorted_value),
        .last_out     (out_ch.last_out),
        .dropped      (out_ch.dropped)
    );

endmodule

FILE: sim/tb_heap_sort_engine.sv
`timescale 1ns / 1ps

module tb_heap_sort_engine;
    import hse_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 260;
    localparam int DRAIN_CYCLES = 40;

    // How the values of one set are drawn.
    typedef enum int {
        MIX_FULL,
        MIX_NARROW,
        MIX_EDGE,
        MIX_NEGATIVE
    } value_mix_t;

    // One sorted word as it should leave the block.
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last_out;
        logic                     dropped;
    } sorted_word_t;

    // One row of the directed table: fill words first, then the row's own word.
    // A pinned row closes a set of one value whose result is typed in.
    typedef struct {
        int                       fill;
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     pinned;
        logic signed [DATA_W-1:0] pin_value;
        logic                     pin_dropped;
    } dir_row_t;

    localparam int DIR_ROWS = 17;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{0,  32'sh7fffffff, 1'b1, 1'b1, 32'sh7fffffff, 1'b0},
        '{0,  32'sh80000000, 1'b1, 1'b1, 32'sh80000000, 1'b0},
        '{0,  32'sh00000000, 1'b1, 1'b1, 32'sh00000000, 1'b0},
        '{0,  32'shffffffff, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{0,  32'sh7fffffff, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{0,  32'sh80000000, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{0,  32'sh00000001, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{0,  32'shffffffff, 1'b1, 1'b0, 32'sh0, 1'b0},
        '{0,  32'sh00000005, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{0,  32'sh00000004, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{0,  32'sh00000003, 1'b1, 1'b0, 32'sh0, 1'b0},
        '{0,  -32'sd100,     1'b0, 1'b0, 32'sh0, 1'b0},
        '{0,  -32'sd3,       1'b0, 1'b0, 32'sh0, 1'b0},
        '{0,  -32'sd50,      1'b1, 1'b0, 32'sh0, 1'b0},
        '{63, 32'sh55555555, 1'b1, 1'b0, 32'sh0, 1'b0},
        '{64, -32'sd7,       1'b1, 1'b0, 32'sh0, 1'b0},
        '{70, 32'sh00000000, 1'b1, 1'b0, 32'sh0, 1'b0}
    };

    logic clk;
    logic rst_n;

    hse_in_if  in_ch ();
    hse_out_if out_ch ();

    heap_sort_engine dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Predictor state: the values of the open set and its drop flag.
    logic signed [DATA_W-1:0] set_values [CAPACITY];
    int                       set_fill;
    bit                       set_overflow;

    sorted_word_t pending_words [$];

    int fail_count;
    int items_sent;
    int sets_closed;
    int overflow_sets;
    int words_checked;
    int cycle_count;

    int quiet_left;
    int stall_left;

    // Free-running clock, 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d words still expected", $time,
                     pending_words.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: long open stretches, short stalls and now and then a long stall.
    always @(posedge clk)
    begin : receiver
        int pick;
        pick = 0;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (quiet_left > 0)
        begin
            quiet_left   = quiet_left - 1;
            out_ch.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left   = stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                quiet_left = $urandom_range(40, 200);
            else if (pick < 20)
                stall_left = $urandom_range(1, 3);
            else if (pick < 23)
                stall_left = $urandom_range(10, 40);
            out_ch.ready <= (pick >= 4 && pick < 23) ? 1'b0 : 1'b1;
        end
    end

    // Compare every accepted output word with the oldest expected one.
    always @(posedge clk)
    begin : word_check
        sorted_word_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_words.size() == 0)
            begin
                fail_count = fail_count + 1;
                $display("%0t: unexpected word: value %0d last_out %0b dropped %0b",
                         $time, out_ch.sorted_value, out_ch.last_out, out_ch.dropped);
            end
            else
            begin
                want = pending_words.pop_front();
                words_checked = words_checked + 1;
                if (out_ch.sorted_value !== want.value
                    || out_ch.last_out !== want.last_out
                    || out_ch.dropped !== want.dropped)
                begin
                    fail_count = fail_count + 1;
                    $display("%0t: mismatch: expected value %0d last_out %0b dropped %0b,",
                             $time, want.value, want.last_out, want.dropped);
                    $display("%0t:           actual   value %0d last_out %0b dropped %0b",
                             $time, out_ch.sorted_value, out_ch.last_out, out_ch.dropped);
                end
            end
        end
    end

    // Draw one value in the given style.
    function automatic logic signed [DATA_W-1:0] pick_value(input value_mix_t mix);
        logic signed [DATA_W-1:0] v;
        v = $urandom;
        case (mix)
            MIX_NARROW:
                v = int'($urandom_range(0, 8)) - 4;
            MIX_EDGE:
                case ($urandom_range(0, 6))
                    0: v = 32'sh80000000;
                    1: v = 32'sh80000001;
                    2: v = -32'sd1;
                    3: v = 32'sd0;
                    4: v = 32'sd1;
                    5: v = 32'sh7ffffffe;
                    default: v = 32'sh7fffffff;
                endcase
            MIX_NEGATIVE:
                v = {1'b1, v[DATA_W-2:0]};
            default:
                v = $urandom;
        endcase
        return v;
    endfunction

    // Idle cycles before a word: mostly none, some short, a few long.
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 0;
        else if (pick < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Store an accepted word; on the closing word, queue the set in ascending order.
    task automatic absorb_word(input logic signed [DATA_W-1:0] v, input logic is_last,
                               input logic pinned, input sorted_word_t pin);
        logic signed [DATA_W-1:0] ordered [CAPACITY];
        logic signed [DATA_W-1:0] key;
        sorted_word_t             w;
        int                       j;
        if (set_fill < CAPACITY)
        begin
            set_values[set_fill] = v;
            set_fill = set_fill + 1;
        end
        else
        begin
            set_overflow = 1'b1;
        end

        if (is_last)
        begin
            if (pinned)
            begin
                pending_words.push_back(pin);
            end
            else
            begin
                // Insertion sort of the stored values, signed.
                for (int i = 0; i < set_fill; i++)
                begin
                    key = set_values[i];
                    j = i - 1;
                    while (j >= 0 && ordered[j] > key)
                    begin
                        ordered[j + 1] = ordered[j];
                        j = j - 1;
                    end
                    ordered[j + 1] = key;
                end
                for (int i = 0; i < set_fill; i++)
                begin
                    w.value    = ordered[i];
                    w.last_out = (i == set_fill - 1);
                    w.dropped  = set_overflow;
                    pending_words.push_back(w);
                end
            end
            sets_closed   = sets_closed + 1;
            overflow_sets = overflow_sets + (set_overflow ? 1 : 0);
            set_fill      = 0;
            set_overflow  = 1'b0;
        end
    endtask

    // Offer one word after a gap and hold it until the block takes it.
    task automatic send_word(input logic signed [DATA_W-1:0] v, input logic is_last,
                             input int gap, input logic pinned, input sorted_word_t pin);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        in_ch.last  <= is_last;
        do @(posedge clk); while (!in_ch.ready);
        items_sent = items_sent + 1;
        absorb_word(v, is_last, pinned, pin);
    endtask

    // Hold the sender until every expected word has come out.
    task automatic wait_for_empty();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_words.size() != 0);
    endtask

    initial
    begin : stimulus
        sorted_word_t no_pin;
        sorted_word_t pin;
        value_mix_t   mix;
        int           random_sent;
        int           set_size;
        int           set_index;
        int           pick;
        bit           burst;

        no_pin       = '{value: '0, last_out: 1'b0, dropped: 1'b0};
        random_sent  = 0;
        set_index    = 0;
        set_fill     = 0;
        set_overflow = 1'b0;
        fail_count   = 0;
        items_sent   = 0;
        sets_closed  = 0;
        overflow_sets = 0;
        words_checked = 0;
        cycle_count  = 0;
        quiet_left   = 0;
        stall_left   = 0;

        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        in_ch.last  <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: single-value sets at the extremes, equal and negative
        // values, a set that fills the store exactly and two that overflow it.
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            for (int k = 0; k < dir_table[r].fill; k++)
                send_word(pick_value(value_mix_t'(k % 4)), 1'b0, pick_gap(), 1'b0, no_pin);
            pin = '{value: dir_table[r].pin_value, last_out: 1'b1,
                    dropped: dir_table[r].pin_dropped};
            send_word(dir_table[r].value, dir_table[r].last, pick_gap(),
                      dir_table[r].pinned, pin);
            if (r == 2)
                wait_for_empty();
        end

        // Random sets: mostly small, some medium, a few near, at or past capacity.
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                set_size = $urandom_range(1, 12);
            else if (pick < 92)
                set_size = $urandom_range(13, 40);
            else
                set_size = $urandom_range(60, 70);
            mix   = value_mix_t'($urandom_range(0, 3));
            burst = ($urandom_range(0, 4) == 0);

            if (set_index == 6 || $urandom_range(0, 24) == 0)
                wait_for_empty();

            for (int k = 0; k < set_size; k++)
                send_word(pick_value(mix), k == set_size - 1, burst ? 0 : pick_gap(),
                          1'b0, no_pin);
            random_sent = random_sent + set_size;
            set_index   = set_index + 1;
        end

        // Let the last set drain, then allow the block to settle.
        in_ch.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words in %0d sets (%0d of them over capacity).",
                 items_sent, sets_closed, overflow_sets);
        $display("Checked %0d sorted words; %0d failures.", words_checked, fail_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
